// ===== design/nps_pkg.sv =====
// Shared types and constants for the nearest point search core.
// No dependencies; every other file but nps_ram imports this package.
package nps_pkg;

	localparam int COORD_W = 24;
	localparam int ID_W    = 20;
	localparam int DIST_W  = 50;
	localparam int OP_W    = 2;
	localparam int N_AXES  = 3;
	localparam int REC_W   = N_AXES * COORD_W + ID_W;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ID_W-1:0]           pid_t;
	typedef logic [DIST_W-1:0]         dist_t;
	typedef logic [OP_W-1:0]           op_t;

	// One stored point on its way down the row of distance cells.
	typedef struct packed {
		logic                    valid;
		logic                    last;
		pid_t                    id;
		coord_t [N_AXES-1:0]     crd;
		dist_t                   sum;
	} lane_t;

	// Control from the sequencer to the best-point tracker.
	typedef struct packed {
		logic start_scan;
		logic start_empty;
		logic take;
	} trk_ctl_t;

	// Status and result from the best-point tracker.
	typedef struct packed {
		logic  done;
		logic  empty;
		pid_t  id;
		dist_t sq_dist;
	} trk_res_t;

endpackage

// ===== design/nps_if.sv =====
// Request and result channel interfaces, valid/ready handshake.
// Depends on nps_pkg for the payload types.
interface nps_cmd_if import nps_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    operation;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	pid_t   point_id;

	modport source (output valid, operation, pos_x, pos_y, pos_z, point_id, input ready);
	modport sink   (input valid, operation, pos_x, pos_y, pos_z, point_id, output ready);
endinterface

interface nps_res_if import nps_pkg::*; ();
	logic  valid;
	logic  ready;
	pid_t  nearest_id;
	dist_t min_sq_dist;
	logic  set_empty;

	modport source (output valid, nearest_id, min_sq_dist, set_empty, input ready);
	modport sink   (input valid, nearest_id, min_sq_dist, set_empty, output ready);
endinterface

// ===== design/nps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/nps_cell.sv =====
// One distance cell: holds one query coordinate, adds the squared difference
// for its axis to the running sum and hands the point on. Uses nps_pkg.
module nps_cell import nps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   qry_ld,
	input  coord_t qry_crd,
	input  lane_t  lane_in,
	output lane_t  lane_out
);

	coord_t                  query_q;
	lane_t                   lane_s1, lane_s2, lane_s3;
	lane_t                   lane_nx;
	logic [COORD_W:0]        absd_s1;
	dist_t                   sq_s2;
	logic signed [COORD_W:0] diff;

	always_ff @(posedge clk) begin
		if (qry_ld) begin
			query_q <= qry_crd;
		end
	end

	assign diff = {lane_in.crd[0][COORD_W-1], lane_in.crd[0]} - {query_q[COORD_W-1], query_q};

	// Add this axis to the running sum.
	always_comb begin
		lane_nx     = lane_s2;
		lane_nx.sum = lane_s2.sum + sq_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
			lane_s2 <= '0;
			lane_s3 <= '0;
			absd_s1 <= '0;
			sq_s2   <= '0;
		end else begin
			lane_s1 <= lane_in;
			absd_s1 <= diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
			lane_s2 <= lane_s1;
			sq_s2   <= DIST_W'(absd_s1) * DIST_W'(absd_s1);
			lane_s3 <= lane_nx;
		end
	end

	// Rotate the coordinates so the next cell sees its own axis in slot zero.
	always_comb begin
		lane_out = lane_s3;
		for (int k = 0; k < N_AXES; k++) begin
			lane_out.crd[k] = lane_s3.crd[(k + 1) % N_AXES];
		end
	end

endmodule

// ===== design/nps_best.sv =====
// Best-point tracker: keeps the strictly smallest distance seen in a scan
// and holds the finished result until the output register takes it. Uses nps_pkg.
module nps_best import nps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  trk_ctl_t ctl,
	input  lane_t    lane,
	output trk_res_t res
);

	logic  first_q, done_q, empty_q;
	pid_t  id_q;
	dist_t dist_q;
	logic  upd;

	assign upd = lane.valid && (first_q || (lane.sum < dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			done_q  <= 1'b0;
			empty_q <= 1'b0;
			id_q    <= '0;
			dist_q  <= '0;
		end else begin
			if (ctl.take) begin
				done_q <= 1'b0;
			end
			if (ctl.start_scan) begin
				first_q <= 1'b1;
				empty_q <= 1'b0;
			end else if (ctl.start_empty) begin
				done_q  <= 1'b1;
				empty_q <= 1'b1;
				id_q    <= '0;
				dist_q  <= '0;
			end else begin
				if (upd) begin
					first_q <= 1'b0;
					id_q    <= lane.id;
					dist_q  <= lane.sum;
				end
				if (lane.valid && lane.last) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done    = done_q;
	assign res.empty   = empty_q;
	assign res.id      = id_q;
	assign res.sq_dist = dist_q;

endmodule

// ===== design/nearest_point_search_core.sv =====
// Channel  | Role      | Payload
// cmd      | request   | operation, pos_x, pos_y, pos_z, point_id
// result   | result    | nearest_id, min_sq_dist, set_empty
//
// Clear and append leave the block ready for another request. A query reads
// the point memory once per cycle, and each point crosses a row of three
// distance cells (three stages each) into the tracker. The result register
// lets a new request in while an earlier result waits; the next query then
// holds at the end of its scan until that result is taken. Reset clears the
// point count but not the point memory, which needs no clearing pass.
module nearest_point_search_core import nps_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	nps_cmd_if.sink   cmd,
	nps_res_if.source result
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q, idx_q;
	logic             cmd_fire, is_full, wr_en, rd_en, rd_last;
	logic             rd_vld_q, rd_last_q;
	logic [REC_W-1:0] rd_data;
	lane_t            lanes [N_AXES+1];
	coord_t           qry [N_AXES];
	trk_ctl_t         tctl;
	trk_res_t         tres;
	logic             out_vld_q;
	pid_t             out_id_q;
	dist_t            out_dist_q;
	logic             out_empty_q;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_full   = (count_q == CW'(MAX_POINTS));
	assign wr_en     = cmd_fire && (cmd.operation == OP_APPEND) && !is_full;
	assign rd_en     = (state_q == ST_SCAN);
	assign rd_last   = (idx_q == count_q - CW'(1));

	nps_ram #(.WIDTH(REC_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata ({cmd.pos_x, cmd.pos_y, cmd.pos_z, cmd.point_id}),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			rd_vld_q  <= rd_en;
			rd_last_q <= rd_en && rd_last;
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.operation == OP_CLEAR) begin
							count_q <= '0;
						end else if (wr_en) begin
							count_q <= count_q + CW'(1);
						end else if (cmd.operation == OP_QUERY) begin
							idx_q   <= '0;
							state_q <= (count_q == '0) ? ST_WAIT : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (rd_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (tctl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Unpack the memory word into the head of the cell row.
	always_comb begin
		lanes[0].valid  = rd_vld_q;
		lanes[0].last   = rd_last_q;
		lanes[0].id     = rd_data[ID_W-1:0];
		lanes[0].crd[0] = rd_data[REC_W-1 -: COORD_W];
		lanes[0].crd[1] = rd_data[REC_W-1-COORD_W -: COORD_W];
		lanes[0].crd[2] = rd_data[REC_W-1-2*COORD_W -: COORD_W];
		lanes[0].sum    = '0;
	end

	assign qry[0] = cmd.pos_x;
	assign qry[1] = cmd.pos_y;
	assign qry[2] = cmd.pos_z;

	for (genvar g = 0; g < N_AXES; g++) begin : g_cell
		nps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.qry_ld   (cmd_fire && (cmd.operation == OP_QUERY)),
			.qry_crd  (qry[g]),
			.lane_in  (lanes[g]),
			.lane_out (lanes[g+1])
		);
	end

	assign tctl.start_scan  = cmd_fire && (cmd.operation == OP_QUERY) && (count_q != '0);
	assign tctl.start_empty = cmd_fire && (cmd.operation == OP_QUERY) && (count_q == '0);
	assign tctl.take        = tres.done && (!out_vld_q || result.ready);

	nps_best u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.lane   (lanes[N_AXES]),
		.res    (tres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (tctl.take) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tctl.take) begin
			out_id_q    <= tres.id;
			out_dist_q  <= tres.sq_dist;
			out_empty_q <= tres.empty;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.nearest_id  = out_id_q;
	assign result.min_sq_dist = out_dist_q;
	assign result.set_empty   = out_empty_q;

endmodule

// ===== design/nps_checker.sv =====
// Port-level checks for nearest_point_search_core, attached by bind.
// Depends on nps_pkg for the payload types and operation codes.
module nps_checker import nps_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cmd_valid,
	input logic  cmd_ready,
	input op_t   cmd_operation,
	input logic  res_valid,
	input logic  res_ready,
	input pid_t  res_nearest_id,
	input dist_t res_min_sq_dist,
	input logic  res_set_empty
);

	// Hold a stalled result.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_nearest_id)
			&& $stable(res_min_sq_dist) && $stable(res_set_empty))
		else $error("stalled result changed");

	// A query keeps the block busy for at least the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_operation == OP_QUERY) |=> !cmd_ready)
		else $error("request accepted straight after a query");

	// Every other request leaves the block ready.
	a_other_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_operation != OP_QUERY) |=> cmd_ready)
		else $error("block stalled after a non-query request");

	// An empty set reports zero id and zero distance.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_set_empty |-> (res_nearest_id == '0) && (res_min_sq_dist == '0))
		else $error("empty result carries data");

endmodule

bind nearest_point_search_core nps_checker u_nps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.cmd_operation   (cmd.operation),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_nearest_id  (result.nearest_id),
	.res_min_sq_dist (result.min_sq_dist),
	.res_set_empty   (result.set_empty)
);
